>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check on the rising clock edge, off during reset.
`define DGVG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dgvg check failed");

// Overlapping implication on the rising clock edge, off during reset.
`define DGVG_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgvg implication failed");

`endif

>>> hw/rtl/dgvg_pkg.sv
`timescale 1ns / 1ps

package dgvg_pkg;

    localparam int MAX_GRID   = 256;
    localparam int GRID_W     = 9;
    localparam int COORD_W    = 8;
    localparam int IDX_W      = 16;
    localparam int Q_W        = 16;
    localparam int MAG_W      = 15;
    localparam int PROD_W     = 29;
    localparam int FRAC_BITS  = 14;
    localparam int ONE_Q14    = 16384;

    localparam int DIV_BITS   = 16;
    localparam int DIV_REM_W  = COORD_W + DIV_BITS;

    localparam int SQRT_BITS  = 16;
    localparam int SQRT_ARG_W = 2 * SQRT_BITS;
    localparam int SQRT_REM_W = SQRT_BITS + 4;

    localparam int S_X        = DIV_BITS + 1;
    localparam int S_SQ       = S_X + 1;
    localparam int S_SQRT_OUT = S_SQ + SQRT_BITS;
    localparam int S_ROOT     = S_SQRT_OUT + 1;
    localparam int S_PROD     = S_ROOT + 1;
    localparam int S_OUT      = S_PROD + 1;
    localparam int LATENCY    = S_OUT;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0]   vertex_index;
        logic signed [Q_W-1:0] disk_u;
        logic signed [Q_W-1:0] disk_v;
        logic               quad_valid;
        logic [IDX_W-1:0]   quad_number;
        logic [IDX_W-1:0]   corner_a;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_c;
        logic [IDX_W-1:0]   corner_d;
        logic               out_of_range;
    } result_t;

endpackage

>>> hw/rtl/dgvg_div_pipe.sv
`timescale 1ns / 1ps

module dgvg_div_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [dgvg_pkg::COORD_W-1:0] in_row,
    input  logic [dgvg_pkg::COORD_W-1:0] in_col,
    input  logic [dgvg_pkg::COORD_W-1:0] in_d,
    output logic                         out_valid,
    output logic [dgvg_pkg::DIV_BITS-1:0] out_qx,
    output logic [dgvg_pkg::DIV_BITS-1:0] out_qy
);

    localparam int QB = dgvg_pkg::DIV_BITS;
    localparam int RW = dgvg_pkg::DIV_REM_W;
    localparam int CW = dgvg_pkg::COORD_W;

    logic          valid_reg [QB];
    logic [RW-1:0] remx_reg  [QB];
    logic [RW-1:0] remy_reg  [QB];
    logic [QB-1:0] qx_reg    [QB];
    logic [QB-1:0] qy_reg    [QB];
    logic [CW:0]   dd_reg    [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;

        logic          valid_in;
        logic [RW-1:0] remx_in;
        logic [RW-1:0] remy_in;
        logic [QB-1:0] qx_in;
        logic [QB-1:0] qy_in;
        logic [CW:0]   dd_in;
        logic [RW-1:0] trial;
        logic          gex;
        logic          gey;
        logic [RW-1:0] remx_next;
        logic [RW-1:0] remy_next;
        logic [QB-1:0] qx_next;
        logic [QB-1:0] qy_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign remx_in  = {in_row, QB'(0)} + RW'(in_d);
            assign remy_in  = {in_col, QB'(0)} + RW'(in_d);
            assign qx_in    = '0;
            assign qy_in    = '0;
            assign dd_in    = {in_d, 1'b0};
        end
        else begin : g_chain
            assign valid_in = valid_reg[k-1];
            assign remx_in  = remx_reg[k-1];
            assign remy_in  = remy_reg[k-1];
            assign qx_in    = qx_reg[k-1];
            assign qy_in    = qy_reg[k-1];
            assign dd_in    = dd_reg[k-1];
        end

        assign trial     = RW'(dd_in) << B;
        assign gex       = remx_in >= trial;
        assign gey       = remy_in >= trial;
        assign remx_next = gex ? remx_in - trial : remx_in;
        assign remy_next = gey ? remy_in - trial : remy_in;
        assign qx_next   = qx_in | (QB'(gex) << B);
        assign qy_next   = qy_in | (QB'(gey) << B);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            remx_reg[k] <= remx_next;
            remy_reg[k] <= remy_next;
            qx_reg[k]   <= qx_next;
            qy_reg[k]   <= qy_next;
            dd_reg[k]   <= dd_in;
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign out_qx    = qx_reg[QB-1];
    assign out_qy    = qy_reg[QB-1];

endmodule

>>> hw/rtl/dgvg_isqrt_pipe.sv
`timescale 1ns / 1ps

module dgvg_isqrt_pipe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [dgvg_pkg::SQRT_ARG_W-1:0] in_arg_x,
    input  logic [dgvg_pkg::SQRT_ARG_W-1:0] in_arg_y,
    output logic                            out_valid,
    output logic [dgvg_pkg::SQRT_BITS-1:0]  out_root_x,
    output logic [dgvg_pkg::SQRT_BITS-1:0]  out_root_y
);

    localparam int RB = dgvg_pkg::SQRT_BITS;
    localparam int AW = dgvg_pkg::SQRT_ARG_W;
    localparam int RW = dgvg_pkg::SQRT_REM_W;

    logic          valid_reg [RB];
    logic [AW-1:0] argx_reg  [RB];
    logic [AW-1:0] argy_reg  [RB];
    logic [RW-1:0] remx_reg  [RB];
    logic [RW-1:0] remy_reg  [RB];
    logic [RB-1:0] rootx_reg [RB];
    logic [RB-1:0] rooty_reg [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic          valid_in;
        logic [AW-1:0] argx_in;
        logic [AW-1:0] argy_in;
        logic [RW-1:0] remx_in;
        logic [RW-1:0] remy_in;
        logic [RB-1:0] rootx_in;
        logic [RB-1:0] rooty_in;
        logic [RW-1:0] catx;
        logic [RW-1:0] caty;
        logic [RW-1:0] trialx;
        logic [RW-1:0] trialy;
        logic          gex;
        logic          gey;
        logic [RW-1:0] remx_next;
        logic [RW-1:0] remy_next;
        logic [RB-1:0] rootx_next;
        logic [RB-1:0] rooty_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign argx_in  = in_arg_x;
            assign argy_in  = in_arg_y;
            assign remx_in  = '0;
            assign remy_in  = '0;
            assign rootx_in = '0;
            assign rooty_in = '0;
        end
        else begin : g_chain
            assign valid_in = valid_reg[k-1];
            assign argx_in  = argx_reg[k-1];
            assign argy_in  = argy_reg[k-1];
            assign remx_in  = remx_reg[k-1];
            assign remy_in  = remy_reg[k-1];
            assign rootx_in = rootx_reg[k-1];
            assign rooty_in = rooty_reg[k-1];
        end

        assign catx       = {remx_in[RW-3:0], argx_in[AW-1 -: 2]};
        assign caty       = {remy_in[RW-3:0], argy_in[AW-1 -: 2]};
        assign trialx     = RW'({rootx_in, 2'b01});
        assign trialy     = RW'({rooty_in, 2'b01});
        assign gex        = catx >= trialx;
        assign gey        = caty >= trialy;
        assign remx_next  = gex ? catx - trialx : catx;
        assign remy_next  = gey ? caty - trialy : caty;
        assign rootx_next = {rootx_in[RB-2:0], gex};
        assign rooty_next = {rooty_in[RB-2:0], gey};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            argx_reg[k]  <= argx_in << 2;
            argy_reg[k]  <= argy_in << 2;
            remx_reg[k]  <= remx_next;
            remy_reg[k]  <= remy_next;
            rootx_reg[k] <= rootx_next;
            rooty_reg[k] <= rooty_next;
        end
    end

    assign out_valid  = valid_reg[RB-1];
    assign out_root_x = rootx_reg[RB-1];
    assign out_root_y = rooty_reg[RB-1];

endmodule

>>> hw/rtl/disk_grid_vertex_generator.sv
`timescale 1ns / 1ps
// Path: input, quotient pipe, magnitude, square, sqrt pipe, round, product, output.
// Throughput: one grid point per clock; busy never rises and results cannot be held off.
// Depth comes from the 16-stage quotient pipeline and the 16-stage square-root pipeline.
// Reset: rst_n low clears every in-flight transaction and sets grid_size to 2.

module disk_grid_vertex_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dgvg_pkg::point_t            point,
    output logic                        done,
    output dgvg_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dgvg_pkg::GRID_W-1:0] cfg_data
);

    localparam int GW       = dgvg_pkg::GRID_W;
    localparam int CW       = dgvg_pkg::COORD_W;
    localparam int IW       = dgvg_pkg::IDX_W;
    localparam int QW       = dgvg_pkg::Q_W;
    localparam int MW       = dgvg_pkg::MAG_W;
    localparam int PW       = dgvg_pkg::PROD_W;
    localparam int FB       = dgvg_pkg::FRAC_BITS;
    localparam int RB       = dgvg_pkg::SQRT_BITS;
    localparam int AW       = dgvg_pkg::SQRT_ARG_W;
    localparam int XW       = CW + GW;
    localparam int META_LEN = dgvg_pkg::S_PROD + 1;
    localparam int CL_LEN   = dgvg_pkg::S_PROD - dgvg_pkg::S_X + 1;
    localparam int CL_ROOT  = dgvg_pkg::S_ROOT - dgvg_pkg::S_X;
    localparam int CL_PROD  = dgvg_pkg::S_PROD - dgvg_pkg::S_X;
    localparam logic [QW-1:0]   ONE     = QW'(dgvg_pkg::ONE_Q14);
    localparam logic [PW:0]     HALF_SQ = (PW + 1)'(2 * dgvg_pkg::ONE_Q14 * dgvg_pkg::ONE_Q14);
    localparam logic [PW:0]     RND     = (PW + 1)'(dgvg_pkg::ONE_Q14 / 2);

    typedef struct packed {
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic [GW-1:0] n;
    } meta_t;

    typedef struct packed {
        logic          xneg;
        logic [MW-1:0] xmag;
        logic          yneg;
        logic [MW-1:0] ymag;
    } coord_t;

    typedef struct packed {
        logic [IW-1:0] vidx;
        logic [IW-1:0] qnum;
        logic [IW-1:0] ca;
        logic [IW-1:0] cb;
        logic [IW-1:0] cd;
    } index_t;

    logic [GW-1:0]      grid_size_reg;
    logic [GW-1:0]      n_sat;
    logic               accept;
    logic               valid0_reg;
    meta_t              meta_reg [META_LEN];
    coord_t             cl_reg   [CL_LEN];
    coord_t             cl_next;

    logic               div_valid;
    logic [QW-1:0]      qx;
    logic [QW-1:0]      qy;

    logic               xv_reg;
    logic               sqv_reg;
    logic [PW-1:0]      sqx_reg;
    logic [PW-1:0]      sqy_reg;
    logic [AW-1:0]      argx;
    logic [AW-1:0]      argy;

    logic               sqrt_valid;
    logic [RB-1:0]      sx;
    logic [RB-1:0]      sy;

    logic               rtv_reg;
    logic [MW-1:0]      rootx_reg;
    logic [MW-1:0]      rooty_reg;
    logic               prv_reg;
    logic [PW-1:0]      produ_reg;
    logic [PW-1:0]      prodv_reg;

    logic [XW-1:0]      ixn_reg;
    logic [XW-1:0]      im1n_reg;
    logic [XW-1:0]      im1d_reg;
    index_t             idx_reg;
    index_t             idx_next;

    logic               done_reg;
    dgvg_pkg::result_t  result_reg;
    dgvg_pkg::result_t  result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GW'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            grid_size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (grid_size_reg < GW'(2))
        begin
            n_sat = GW'(2);
        end
        else if (grid_size_reg > GW'(dgvg_pkg::MAX_GRID))
        begin
            n_sat = GW'(dgvg_pkg::MAX_GRID);
        end
        else
        begin
            n_sat = grid_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            xv_reg     <= 1'b0;
            sqv_reg    <= 1'b0;
            rtv_reg    <= 1'b0;
            prv_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid0_reg <= accept;
            xv_reg     <= div_valid;
            sqv_reg    <= xv_reg;
            rtv_reg    <= sqrt_valid;
            prv_reg    <= rtv_reg;
            done_reg   <= prv_reg;
        end
    end

    // advance the grid point alongside the arithmetic
    always_ff @(posedge clk)
    begin
        meta_reg[0] <= '{row: point.row, col: point.col, n: n_sat};
        for (int k = 1; k < META_LEN; k++)
        begin
            meta_reg[k] <= meta_reg[k-1];
        end
    end

    dgvg_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid0_reg),
        .in_row    (meta_reg[0].row),
        .in_col    (meta_reg[0].col),
        .in_d      (CW'(meta_reg[0].n - GW'(1))),
        .out_valid (div_valid),
        .out_qx    (qx),
        .out_qy    (qy)
    );

    always_comb
    begin
        cl_next.xneg = qx < ONE;
        cl_next.xmag = MW'(cl_next.xneg ? ONE - qx : qx - ONE);
        cl_next.yneg = qy < ONE;
        cl_next.ymag = MW'(cl_next.yneg ? ONE - qy : qy - ONE);
    end

    always_ff @(posedge clk)
    begin
        cl_reg[0] <= cl_next;
        for (int k = 1; k < CL_LEN; k++)
        begin
            cl_reg[k] <= cl_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= PW'(cl_reg[0].xmag) * PW'(cl_reg[0].xmag);
        sqy_reg <= PW'(cl_reg[0].ymag) * PW'(cl_reg[0].ymag);
    end

    assign argx = AW'({HALF_SQ - (PW + 1)'(sqx_reg), 1'b0});
    assign argy = AW'({HALF_SQ - (PW + 1)'(sqy_reg), 1'b0});

    dgvg_isqrt_pipe u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sqv_reg),
        .in_arg_x   (argx),
        .in_arg_y   (argy),
        .out_valid  (sqrt_valid),
        .out_root_x (sx),
        .out_root_y (sy)
    );

    always_ff @(posedge clk)
    begin
        rootx_reg <= MW'(((RB + 1)'(sx) + (RB + 1)'(1)) >> 1);
        rooty_reg <= MW'(((RB + 1)'(sy) + (RB + 1)'(1)) >> 1);
        produ_reg <= PW'(cl_reg[CL_ROOT].xmag) * PW'(rooty_reg);
        prodv_reg <= PW'(cl_reg[CL_ROOT].ymag) * PW'(rootx_reg);
    end

    always_ff @(posedge clk)
    begin
        ixn_reg  <= XW'(meta_reg[dgvg_pkg::S_ROOT-1].row) * XW'(meta_reg[dgvg_pkg::S_ROOT-1].n);
        im1n_reg <= XW'(meta_reg[dgvg_pkg::S_ROOT-1].row - CW'(1))
                    * XW'(meta_reg[dgvg_pkg::S_ROOT-1].n);
        im1d_reg <= XW'(meta_reg[dgvg_pkg::S_ROOT-1].row - CW'(1))
                    * XW'(meta_reg[dgvg_pkg::S_ROOT-1].n - GW'(1));
        idx_reg  <= idx_next;
    end

    always_comb
    begin
        idx_next.vidx = IW'(ixn_reg + XW'(meta_reg[dgvg_pkg::S_ROOT].col));
        idx_next.qnum = IW'(im1d_reg + XW'(meta_reg[dgvg_pkg::S_ROOT].col) - XW'(1));
        idx_next.ca   = IW'(im1n_reg + XW'(meta_reg[dgvg_pkg::S_ROOT].col) - XW'(1));
        idx_next.cb   = IW'(im1n_reg + XW'(meta_reg[dgvg_pkg::S_ROOT].col));
        idx_next.cd   = IW'(ixn_reg + XW'(meta_reg[dgvg_pkg::S_ROOT].col) - XW'(1));
    end

    always_comb
    begin
        logic [MW-1:0] pu;
        logic [MW-1:0] pv;
        logic          oor;
        logic          quad;
        meta_t         m;

        m    = meta_reg[dgvg_pkg::S_PROD];
        pu   = MW'(((PW + 1)'(produ_reg) + RND) >> FB);
        pv   = MW'(((PW + 1)'(prodv_reg) + RND) >> FB);
        oor  = (GW'(m.row) >= m.n) || (GW'(m.col) >= m.n);
        quad = !oor && (m.row != '0) && (m.col != '0);

        result_next              = '0;
        result_next.out_of_range = oor;
        if (!oor)
        begin
            result_next.vertex_index = idx_reg.vidx;
            result_next.disk_u       = cl_reg[CL_PROD].xneg ? -QW'(pu) : QW'(pu);
            result_next.disk_v       = cl_reg[CL_PROD].yneg ? -QW'(pv) : QW'(pv);
        end
        if (quad)
        begin
            result_next.quad_valid  = 1'b1;
            result_next.quad_number = idx_reg.qnum;
            result_next.corner_a    = idx_reg.ca;
            result_next.corner_b    = idx_reg.cb;
            result_next.corner_c    = idx_reg.vidx;
            result_next.corner_d    = idx_reg.cd;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/dgvg_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgvg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input dgvg_pkg::point_t            point,
    input logic                        done,
    input dgvg_pkg::result_t           result,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [dgvg_pkg::GRID_W-1:0] cfg_data
);

    localparam int LAG = dgvg_pkg::LATENCY + 1;

    logic unused_ok;
    assign unused_ok = ^{point, cfg_valid, cfg_ready, cfg_data};

    `DGVG_ASSERT(a_done_follows_accept, !done || $past(start && !busy, LAG))

    `DGVG_IMPLY(a_oor_zeroes, done && result.out_of_range, result.vertex_index == 16'd0 && result.disk_u == 16'sd0 && result.disk_v == 16'sd0 && !result.quad_valid)

    `DGVG_IMPLY(a_no_quad_zeroes, done && !result.quad_valid, result.quad_number == 16'd0 && result.corner_a == 16'd0 && result.corner_b == 16'd0 && result.corner_c == 16'd0 && result.corner_d == 16'd0)

    `DGVG_IMPLY(a_quad_corners, done && result.quad_valid, result.corner_c == result.vertex_index && 16'(result.corner_b - result.corner_a) == 16'd1 && 16'(result.corner_c - result.corner_d) == 16'd1)

endmodule

bind disk_grid_vertex_generator dgvg_checker u_dgvg_checker (.*);
